// File: src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants of the bounded double-ended queue
// Request codes, field widths, result packing and the cell control bundle.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Field widths
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned DEPTH_D = 64;
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    // Result word layout, lowest bit first
    localparam int unsigned OUT_OK_LSB    = 0;
    localparam int unsigned OUT_FRONT_LSB = 1;
    localparam int unsigned OUT_REAR_LSB  = OUT_FRONT_LSB + DATA_W;
    localparam int unsigned OUT_EMPTY_LSB = OUT_REAR_LSB + DATA_W;
    localparam int unsigned OUT_FULL_LSB  = OUT_EMPTY_LSB + 1;
    localparam int unsigned OUT_OCC_LSB   = OUT_FULL_LSB + 1;
    localparam int unsigned OUT_USED_W    = OUT_OCC_LSB + CNT_W;
    localparam int unsigned OUT_W         = ((OUT_USED_W + 7) / 8) * 8;

    // Request codes
    typedef enum logic [MODE_W-1:0] {
        MODE_NONE       = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_PUSH_BACK  = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_POP_BACK   = 3'd4
    } t_mode;

    // Control shared by every cell of one chain
    typedef struct packed {
        logic              shift_up;    // take the lower neighbor's word
        logic              shift_down;  // take the upper neighbor's word
        logic              load;        // load value into the cell at tail
        logic [CNT_W-1:0]  tail;        // first unused position
        logic [DATA_W-1:0] value;       // word entering the chain
    } t_chain_ctl;

endpackage

// File: src/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue: bounded deque of 32-bit words
// Two mirrored cell chains keep the front and the rear word at cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s-side stream: tuser carries the mode (none, push
//   front, push back, pop front, pop back), tdata the word to push. Each
//   request gives exactly one result on the m-side stream, in order.
//   The capacity register is written through i_cfg_wr_en / i_cfg_wr_data
//   while no request is in flight; values above DEPTH count as DEPTH.
// Timing:
//   A result is valid in the cycle after its request is taken; one request is
//   taken per cycle while the m-side is not stalled. Both chains update in
//   the cycle the request is taken, each cell moving one word to or from its
//   neighbor, so the next request sees the new state at once.
// Reset:
//   Synchronous, active low. The queue comes up empty with capacity 64;
//   no clearing pass is needed. Stored words are not cleared.
// Stall:
//   The result register holds while the m-side is stalled; a new request
//   is taken in the cycle the held result leaves.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue import bdq_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_D
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // [31:0] value
    input  logic [MODE_W-1:0] i_s_tuser,   // [2:0] mode
    // Result stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,   // [0] ok, [32:1] front_value,
                                           // [64:33] rear_value, [65] empty_res,
                                           // [66] full_res, [73:67] occupancy
    // Capacity register
    input  logic              i_cfg_wr_en,
    input  logic [CNT_W-1:0]  i_cfg_wr_data
);

    localparam int unsigned     CNT_MAX   = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] DEPTH_LIM =
        CNT_W'((DEPTH > CNT_MAX) ? CNT_MAX : DEPTH);
    localparam int unsigned     PAD_W     = OUT_W - OUT_USED_W;

    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic              w_accept;
    logic [CNT_W-1:0]  w_limit;
    logic              w_full;
    logic              w_empty;
    logic              w_ok;
    logic              w_n_empty;
    logic              w_n_full;
    t_chain_ctl        w_fctl;
    t_chain_ctl        w_rctl;
    logic [DATA_W-1:0] w_fhead;
    logic [DATA_W-1:0] w_rhead;
    logic [DATA_W-1:0] w_front;
    logic [DATA_W-1:0] w_rear;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Effective limit and current flags
    assign w_limit = (r_cap > DEPTH_LIM) ? DEPTH_LIM : r_cap;
    assign w_full  = (r_count >= w_limit);
    assign w_empty = (r_count == '0);

    // Request decode: front chain is front-first, rear chain rear-first
    always_comb begin
        w_ok    = 1'b0;
        n_count = r_count;
        w_fctl  = '{shift_up: 1'b0, shift_down: 1'b0, load: 1'b0,
                    tail: r_count, value: i_s_tdata};
        w_rctl  = w_fctl;
        case (t_mode'(i_s_tuser))
            MODE_NONE: begin
                w_ok = 1'b1;
            end
            MODE_PUSH_FRONT: begin
                if (!w_full) begin
                    w_ok            = 1'b1;
                    n_count         = r_count + 1'b1;
                    w_fctl.shift_up = w_accept;
                    w_rctl.load     = w_accept;
                end
            end
            MODE_PUSH_BACK: begin
                if (!w_full) begin
                    w_ok            = 1'b1;
                    n_count         = r_count + 1'b1;
                    w_fctl.load     = w_accept;
                    w_rctl.shift_up = w_accept;
                end
            end
            MODE_POP_FRONT: begin
                if (!w_empty) begin
                    w_ok              = 1'b1;
                    n_count           = r_count - 1'b1;
                    w_fctl.shift_down = w_accept;
                end
            end
            MODE_POP_BACK: begin
                if (!w_empty) begin
                    w_ok              = 1'b1;
                    n_count           = r_count - 1'b1;
                    w_rctl.shift_down = w_accept;
                end
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    bdq_chain #(
        .DEPTH (DEPTH)
    ) u_front_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_fctl),
        .o_head_next (w_fhead)
    );

    bdq_chain #(
        .DEPTH (DEPTH)
    ) u_rear_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_rctl),
        .o_head_next (w_rhead)
    );

    // State after the request
    assign w_n_empty = (n_count == '0);
    assign w_n_full  = (n_count >= w_limit);
    assign w_front   = w_n_empty ? '1 : w_fhead;
    assign w_rear    = w_n_empty ? '1 : w_rhead;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {{PAD_W{1'b0}}, n_count, w_n_full, w_n_empty,
                           w_rear, w_front, w_ok};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// File: src/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell: one storage cell of a queue chain
// Holds one word; shifts from either neighbor or loads when it is the tail.
// ----------------------------------------------------------------------------
module bdq_cell import bdq_pkg::*; #(
    parameter int unsigned IDX = 0
) (
    input  logic              i_clk,
    input  t_chain_ctl        i_ctl,
    input  logic [DATA_W-1:0] i_lower,
    input  logic [DATA_W-1:0] i_upper,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_next
);

    // Cells past the count range can never be the tail
    localparam bit REACH = (IDX < (1 << CNT_W));

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              w_hit;

    assign w_hit = REACH && (i_ctl.tail == CNT_W'(IDX));

    // Next word
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            n_data = i_lower;
        end else if (i_ctl.shift_down) begin
            n_data = i_upper;
        end else if (i_ctl.load && w_hit) begin
            n_data = i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_next = n_data;

endmodule

// File: src/bdq_chain.sv
// ----------------------------------------------------------------------------
// bdq_chain: row of cells with the head entry fixed at cell 0
// Words move one cell per shift; the head's next word is exported.
// ----------------------------------------------------------------------------
module bdq_chain import bdq_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_D
) (
    input  logic              i_clk,
    input  t_chain_ctl        i_ctl,
    output logic [DATA_W-1:0] o_head_next
);

    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DATA_W-1:0] w_next [DEPTH];

    // Each cell sees its two neighbors; the ends see the new word and zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_lower;
        logic [DATA_W-1:0] w_upper;

        if (g == 0) begin : g_first
            assign w_lower = i_ctl.value;
        end else begin : g_mid_lo
            assign w_lower = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_upper = '0;
        end else begin : g_mid_hi
            assign w_upper = w_data[g+1];
        end

        bdq_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (i_ctl),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_data  (w_data[g]),
            .o_next  (w_next[g])
        );
    end

    assign o_head_next = w_next[0];

endmodule

// File: src/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker: port-level checks of the bounded double-ended queue
// Watches result consistency and the result handshake; bound to the top.
// ----------------------------------------------------------------------------
module bdq_checker import bdq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_W-1:0]  o_m_tdata
);

    logic             w_empty;
    logic [CNT_W-1:0] w_occ;

    assign w_empty = o_m_tdata[OUT_EMPTY_LSB];
    assign w_occ   = o_m_tdata[OUT_OCC_LSB +: CNT_W];

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // An accepted request gives a result in the next cycle
    a_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted request gave no result");

    // Empty flag agrees with the occupancy
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_empty == (w_occ == '0)))
        else $error("empty flag and occupancy disagree");

    // An empty queue reports all-ones words at both ends
    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_empty) |->
            (&o_m_tdata[OUT_FRONT_LSB +: DATA_W]) &&
            (&o_m_tdata[OUT_REAR_LSB +: DATA_W]))
        else $error("empty queue shows a stored word");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
